// ===== sv/oaht_pkg.sv =====
// Package with shared types and constants for the open addressing hash table.
package oaht_pkg;

    localparam int SLOT_BITS_DEF   = 8;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_GET  = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;
    localparam logic [1:0] REQ_NEXT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_LIVE    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_OUT
    } state_t;

endpackage

// ===== sv/oaht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/open_addressing_hash_table.sv =====
// Top level of the open addressing hash table with linear probing.
// A request takes one beat in, walks the slot memory one slot at a time
// (read, then compare), and returns one result beat; a probe is bounded by
// the slot count. After reset a clearing pass writes every slot mark empty,
// one slot per cycle, while no request is accepted. Set of a new key walks the
// probe once to find the key and remembers the first free or deleted slot on
// the way.
module open_addressing_hash_table #(
    parameter int SLOT_BITS   = oaht_pkg::SLOT_BITS_DEF,
    parameter int KEY_WIDTH   = oaht_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = oaht_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] key_hash,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  slot,
    output logic [31:0] key_out,
    output logic [31:0] value_out,
    output logic        was_update,
    output logic [8:0]  entry_count
);

    localparam int NSLOTS = 1 << SLOT_BITS;
    localparam int DW = 2 + 32 + KEY_WIDTH + VALUE_WIDTH;

    oaht_pkg::state_t state_reg, state_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [SLOT_BITS:0]   cnt_reg, cnt_next;
    logic [SLOT_BITS:0]   live_reg, live_next;
    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic [SLOT_BITS-1:0] free_reg, free_next;
    logic                 free_ok_reg, free_ok_next;
    logic [1:0]           type_reg;
    logic [31:0]          hash_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [1:0]           st_reg, st_next;
    logic [SLOT_BITS-1:0] rs_reg, rs_next;
    logic [KEY_WIDTH-1:0] rk_reg, rk_next;
    logic [VALUE_WIDTH-1:0] rv_reg, rv_next;
    logic                 upd_reg, upd_next;

    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    logic [DW-1:0]        wdata, rdata;
    logic [1:0]           r_mark;
    logic [31:0]          r_hash;
    logic [KEY_WIDTH-1:0] r_key;
    logic [VALUE_WIDTH-1:0] r_val;

    assign {r_mark, r_hash, r_key, r_val} = rdata;

    oaht_ram #(.WIDTH(DW), .DEPTH(NSLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= oaht_pkg::S_CLEAR;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            live_reg    <= '0;
            cur_reg     <= '0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            live_reg    <= live_next;
            cur_reg     <= cur_next;
            free_ok_reg <= free_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            type_reg <= req_type;
            hash_reg <= key_hash;
            key_reg  <= KEY_WIDTH'(key);
            val_reg  <= VALUE_WIDTH'(value);
        end
        free_reg <= free_next;
        st_reg   <= st_next;
        rs_reg   <= rs_next;
        rk_reg   <= rk_next;
        rv_reg   <= rv_next;
        upd_reg  <= upd_next;
    end

    always_comb
    begin
        logic done;
        logic live;
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        live_next    = live_reg;
        cur_next     = cur_reg;
        free_next    = free_reg;
        free_ok_next = free_ok_reg;
        st_next      = st_reg;
        rs_next      = rs_reg;
        rk_next      = rk_reg;
        rv_next      = rv_reg;
        upd_next     = upd_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = {oaht_pkg::MARK_EMPTY, 32'd0, {KEY_WIDTH{1'b0}}, {VALUE_WIDTH{1'b0}}};
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        done         = 1'b0;
        live         = (r_mark == oaht_pkg::MARK_LIVE);
        case (state_reg)
            oaht_pkg::S_CLEAR:
            begin
                we       = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_BITS'(NSLOTS - 1))
                begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cnt_next     = '0;
                    free_ok_next = 1'b0;
                    st_next      = oaht_pkg::ST_OK;
                    upd_next     = 1'b0;
                    if (req_type == oaht_pkg::REQ_NEXT)
                    begin
                        idx_next = cur_reg + 1'b1;
                        if (live_reg == '0)
                        begin
                            st_next    = oaht_pkg::ST_EMPTY;
                            state_next = oaht_pkg::S_OUT;
                        end
                        else
                        begin
                            state_next = oaht_pkg::S_READ;
                        end
                    end
                    else
                    begin
                        idx_next   = key_hash[SLOT_BITS-1:0];
                        state_next = oaht_pkg::S_READ;
                    end
                end
            end
            oaht_pkg::S_READ:
            begin
                state_next = oaht_pkg::S_CHECK;
            end
            oaht_pkg::S_CHECK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (type_reg == oaht_pkg::REQ_NEXT)
                begin
                    if (live)
                    begin
                        cur_next = idx_reg;
                        rs_next  = idx_reg;
                        rk_next  = r_key;
                        rv_next  = r_val;
                        done     = 1'b1;
                    end
                    else if (cnt_next == (SLOT_BITS+1)'(NSLOTS))
                    begin
                        st_next = oaht_pkg::ST_EMPTY;
                        done    = 1'b1;
                    end
                end
                else
                begin
                    if (!live && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx_reg;
                    end
                    if (live && r_hash == hash_reg && r_key == key_reg)
                    begin
                        rs_next = idx_reg;
                        rk_next = r_key;
                        rv_next = r_val;
                        if (type_reg == oaht_pkg::REQ_SET)
                        begin
                            rv_next  = val_reg;
                            upd_next = 1'b1;
                            state_next = oaht_pkg::S_WRITE;
                        end
                        else if (type_reg == oaht_pkg::REQ_DEL)
                        begin
                            state_next = oaht_pkg::S_WRITE;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    else if (r_mark == oaht_pkg::MARK_EMPTY ||
                             cnt_next == (SLOT_BITS+1)'(NSLOTS))
                    begin
                        if (type_reg == oaht_pkg::REQ_SET)
                        begin
                            if (free_ok_next)
                            begin
                                rs_next    = free_next;
                                rk_next    = key_reg;
                                rv_next    = val_reg;
                                state_next = oaht_pkg::S_WRITE;
                            end
                            else
                            begin
                                st_next = oaht_pkg::ST_FULL;
                                done    = 1'b1;
                            end
                        end
                        else
                        begin
                            st_next = oaht_pkg::ST_NOTFOUND;
                            done    = 1'b1;
                        end
                    end
                end
                if (done)
                begin
                    state_next = oaht_pkg::S_OUT;
                end
                else if (state_next == oaht_pkg::S_CHECK)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_WRITE:
            begin
                we    = 1'b1;
                waddr = rs_reg;
                if (type_reg == oaht_pkg::REQ_DEL)
                begin
                    wdata = {oaht_pkg::MARK_DELETED, hash_reg, rk_reg, rv_reg};
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                end
                else
                begin
                    wdata = {oaht_pkg::MARK_LIVE, hash_reg, key_reg, val_reg};
                    if (!upd_reg)
                    begin
                        live_next = live_reg + 1'b1;
                    end
                end
                state_next = oaht_pkg::S_OUT;
            end
            oaht_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oaht_pkg::S_IDLE;
            end
        endcase
    end

    logic ok;
    assign ok          = (st_reg == oaht_pkg::ST_OK);
    assign status      = st_reg;
    assign slot        = ok ? 8'(rs_reg) : 8'd0;
    assign key_out     = ok ? 32'(rk_reg) : 32'd0;
    assign value_out   = ok ? 32'(rv_reg) : 32'd0;
    assign was_update  = ok & upd_reg;
    assign entry_count = 9'(live_reg);

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the open addressing hash table: directed, random, backpressure and full-table tests.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] key_out;
        logic [31:0] value_out;
        logic        was_update;
        logic [8:0]  entry_count;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [31:0] key_hash;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] key_out;
    logic [31:0] value_out;
    logic        was_update;
    logic [8:0]  entry_count;

    logic [1:0]  shadow_mark [256];
    logic [31:0] shadow_hash [256];
    logic [31:0] shadow_key [256];
    logic [31:0] shadow_value [256];
    int unsigned shadow_live;
    int unsigned shadow_cursor;

    table_result_t expected_results[$];
    logic [31:0] pool_key [64];
    logic [31:0] pool_hash [64];
    int unsigned fail_count;
    int unsigned beats_sent;
    int unsigned beats_checked;
    int unsigned full_hits;
    int unsigned update_hits;
    int unsigned hold_cycles;
    int unsigned stall_left;
    bit          no_idle;

    open_addressing_hash_table uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .key_hash(key_hash), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .slot(slot),
        .key_out(key_out), .value_out(value_out), .was_update(was_update),
        .entry_count(entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int find_live(logic [31:0] h, logic [31:0] k);
        int n;
        for (int i = 0; i < 256; i++)
        begin
            n = (h + i) & 255;
            if (shadow_mark[n] == oaht_pkg::MARK_EMPTY)
                return -1;
            if (shadow_mark[n] == oaht_pkg::MARK_LIVE && shadow_hash[n] == h &&
                shadow_key[n] == k)
                return n;
        end
        return -1;
    endfunction

    function automatic table_result_t predict_table(logic [1:0] op, logic [31:0] h,
                                                     logic [31:0] k, logic [31:0] v);
        table_result_t r;
        int n;
        int c;
        r = '0;
        r.status = oaht_pkg::ST_OK;
        n = -1;
        case (op)
            oaht_pkg::REQ_SET:
            begin
                n = find_live(h, k);
                if (n >= 0)
                begin
                    shadow_value[n] = v;
                    r.was_update = 1'b1;
                    update_hits++;
                end
                else
                begin
                    for (int i = 0; i < 256 && n < 0; i++)
                        if (shadow_mark[(h + i) & 255] != oaht_pkg::MARK_LIVE)
                            n = (h + i) & 255;
                    if (n < 0)
                    begin
                        r.status = oaht_pkg::ST_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        shadow_mark[n] = oaht_pkg::MARK_LIVE;
                        shadow_hash[n] = h;
                        shadow_key[n] = k;
                        shadow_value[n] = v;
                        shadow_live++;
                    end
                end
            end
            oaht_pkg::REQ_GET:
            begin
                n = find_live(h, k);
                if (n < 0)
                    r.status = oaht_pkg::ST_NOTFOUND;
            end
            oaht_pkg::REQ_DEL:
            begin
                n = find_live(h, k);
                if (n < 0)
                    r.status = oaht_pkg::ST_NOTFOUND;
                else
                begin
                    shadow_mark[n] = oaht_pkg::MARK_DELETED;
                    if (shadow_live > 0)
                        shadow_live--;
                end
            end
            default:
            begin
                if (shadow_live == 0)
                    r.status = oaht_pkg::ST_EMPTY;
                else
                begin
                    c = shadow_cursor;
                    for (int i = 0; i < 256 && n < 0; i++)
                    begin
                        c = (c + 1) & 255;
                        if (shadow_mark[c] == oaht_pkg::MARK_LIVE)
                            n = c;
                    end
                    if (n < 0)
                        r.status = oaht_pkg::ST_EMPTY;
                    else
                        shadow_cursor = c;
                end
            end
        endcase
        if (r.status != oaht_pkg::ST_OK)
        begin
            n = -1;
            r.was_update = 1'b0;
        end
        if (n >= 0)
        begin
            r.slot = n[7:0];
            r.key_out = shadow_key[n];
            r.value_out = shadow_value[n];
        end
        r.entry_count = shadow_live[8:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [1:0] op, logic [31:0] h, logic [31:0] k,
                                logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        key_hash <= h;
        key <= k;
        value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_table(op, h, k, v));
        beats_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        table_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no request pending");
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    fail_count++;
                end
                if (slot !== e.slot)
                begin
                    $error("slot expected %0d actual %0d", e.slot, slot);
                    fail_count++;
                end
                if (key_out !== e.key_out)
                begin
                    $error("key_out expected %h actual %h", e.key_out, key_out);
                    fail_count++;
                end
                if (value_out !== e.value_out)
                begin
                    $error("value_out expected %h actual %h", e.value_out, value_out);
                    fail_count++;
                end
                if (was_update !== e.was_update)
                begin
                    $error("was_update expected %0d actual %0d", e.was_update, was_update);
                    fail_count++;
                end
                if (entry_count !== e.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d", e.entry_count, entry_count);
                    fail_count++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic test_directed();
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_GET, 32'h5, 32'h1234, 32'h0);
        send_request(oaht_pkg::REQ_DEL, 32'h5, 32'h1234, 32'h0);
        send_request(oaht_pkg::REQ_SET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_request(oaht_pkg::REQ_SET, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_SET, 32'h0, 32'h0, 32'hA5A5A5A5);
        send_request(oaht_pkg::REQ_SET, 32'h0000FFFF, 32'hFFFFFFFF, 32'h1);
        send_request(oaht_pkg::REQ_GET, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_GET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        send_request(oaht_pkg::REQ_GET, 32'h000000FF, 32'hFFFFFFFF, 32'h0);
        send_request(oaht_pkg::REQ_SET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h5A5A5A5A);
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_NEXT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_DEL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        send_request(oaht_pkg::REQ_GET, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_DEL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        send_request(oaht_pkg::REQ_SET, 32'hFFFFFFFF, 32'h7, 32'h7);
        send_request(oaht_pkg::REQ_DEL, 32'hFFFFFFFF, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_DEL, 32'h0, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_DEL, 32'h0000FFFF, 32'hFFFFFFFF, 32'h0);
        send_request(oaht_pkg::REQ_DEL, 32'hFFFFFFFF, 32'h7, 32'h0);
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        drain_results();
    endtask

    task automatic test_random(int count);
        int idx;
        int r;
        logic [1:0] op;
        for (int i = 0; i < 64; i++)
        begin
            pool_key[i] = $urandom();
            pool_hash[i] = {28'($urandom() >> 4), 4'($urandom_range(0, 15))};
        end
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 35) ? oaht_pkg::REQ_SET :
                 (r < 60) ? oaht_pkg::REQ_GET :
                 (r < 80) ? oaht_pkg::REQ_DEL : oaht_pkg::REQ_NEXT;
            idx = $urandom_range(0, 63);
            no_idle = ((i / 150) % 4 == 3);
            if ($urandom_range(0, 9) == 0)
                send_request(op == oaht_pkg::REQ_SET ? oaht_pkg::REQ_GET : op,
                             $urandom(), $urandom(), $urandom());
            else
                send_request(op, pool_hash[idx], pool_key[idx], $urandom());
            if (i % 200 == 199)
                drain_results();
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            send_request(i % 2 ? oaht_pkg::REQ_GET : oaht_pkg::REQ_NEXT,
                         pool_hash[i], pool_key[i], 32'h0);
        drain_results();
    endtask

    task automatic clear_live_entries();
        for (int n = 0; n < 256; n++)
            if (shadow_mark[n] == oaht_pkg::MARK_LIVE)
                send_request(oaht_pkg::REQ_DEL, shadow_hash[n], shadow_key[n], 32'h0);
        drain_results();
    endtask

    task automatic test_full_table();
        clear_live_entries();
        for (int n = 0; n < 256; n++)
            send_request(oaht_pkg::REQ_SET, n, 32'h1000 + n, $urandom());
        send_request(oaht_pkg::REQ_SET, 32'h10, 32'hDEAD0000, 32'h1);
        send_request(oaht_pkg::REQ_SET, 32'h20, 32'h1020, 32'hCAFEF00D);
        send_request(oaht_pkg::REQ_GET, 32'hFFFFFFFF, 32'hBEEF, 32'h0);
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        drain_results();
        clear_live_entries();
        send_request(oaht_pkg::REQ_NEXT, 32'h0, 32'h0, 32'h0);
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = oaht_pkg::REQ_SET;
        key_hash = '0;
        key = '0;
        value = '0;
        no_idle = 1'b0;
        hold_cycles = 0;
        stall_left = 0;
        fail_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        full_hits = 0;
        update_hits = 0;
        shadow_live = 0;
        shadow_cursor = 0;
        for (int n = 0; n < 256; n++)
        begin
            shadow_mark[n] = oaht_pkg::MARK_EMPTY;
            shadow_hash[n] = '0;
            shadow_key[n] = '0;
            shadow_value[n] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(700);
        test_backpressure();
        test_full_table();
        drain_results();
        repeat (600) @(posedge clk);
        $display("Sent %0d requests and checked %0d results.", beats_sent, beats_checked);
        $display("Covered %0d updates and %0d full-table rejections.", update_hits, full_hits);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
